// ----- sv/limit_order_book_matcher_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the order book matcher.
// Each macro checks a property on the rising edge of clk, outside reset.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH

// The property must hold at every clock edge.
`define LOBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true.
`define LOBM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- sv/lobm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and default sizes of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	// Default ladder size and number of resting orders per price level.
	localparam int PRICE_LEVELS_DEF = 1024;
	localparam int LEVEL_DEPTH_DEF  = 16;

	// Side codes.
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// One incoming order.
	typedef struct packed {
		logic [63:0] order_ref;
		logic        side;
		logic [9:0]  price_tick;
		logic [31:0] quantity;
	} order_t;

	// One acknowledgement.
	typedef struct packed {
		logic [63:0] ack_id;
		logic [31:0] filled_quantity;
		logic [31:0] rested_quantity;
		logic        rest_dropped;
	} ack_t;

endpackage

// ----- sv/lobm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lobm_ram #(
	parameter int DW = 32,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/lobm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_seq
// Sequencer of the matcher: walks price levels, fills resting orders with a
// shared compare and subtract unit, rests the remainder and emits the ack.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_core_assert.svh"

module lobm_seq #(
	parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
	parameter int LEVEL_DEPTH  = lobm_pkg::LEVEL_DEPTH_DEF,
	parameter int TW  = $clog2(PRICE_LEVELS),
	parameter int HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1,
	parameter int CW  = $clog2(LEVEL_DEPTH + 1),
	parameter int SAW = $clog2(PRICE_LEVELS * LEVEL_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lobm_pkg::order_t     in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lobm_pkg::ack_t       out_data,
	output logic                 lvl_we,
	output logic [TW:0]          lvl_waddr,
	output logic [HW+CW-1:0]     lvl_wdata,
	output logic [TW:0]          lvl_raddr,
	input  logic [HW+CW-1:0]     lvl_rdata,
	output logic                 qty_we,
	output logic [SAW:0]         qty_waddr,
	output logic [31:0]          qty_wdata,
	output logic [SAW:0]         qty_raddr,
	input  logic [31:0]          qty_rdata
);
	import lobm_pkg::*;

	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_SCAN_RD  = 4'd2;
	localparam logic [3:0] ST_SCAN_CHK = 4'd3;
	localparam logic [3:0] ST_MATCH    = 4'd4;
	localparam logic [3:0] ST_REST_RD  = 4'd5;
	localparam logic [3:0] ST_REST_CHK = 4'd6;
	localparam logic [3:0] ST_DONE     = 4'd7;

	localparam logic [TW-1:0] TICK_MAX = TW'(PRICE_LEVELS - 1);
	localparam logic [HW-1:0] HEAD_MAX = HW'(LEVEL_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(LEVEL_DEPTH);

	logic [3:0]    state_q, state_d;
	logic [TW:0]   clr_q, clr_d;
	logic [63:0]   id_q, id_d;
	logic          side_q, side_d;
	logic [TW-1:0] tick_q, tick_d;
	logic [TW-1:0] t_q, t_d;
	logic [31:0]   qty_q, qty_d;
	logic [31:0]   orig_q, orig_d;
	logic [HW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   rested_q, rested_d;
	logic          dropped_q, dropped_d;
	ack_t          out_q, out_d;
	logic          out_valid_q, out_valid_d;

	logic [HW-1:0] rd_head, hn;
	logic [CW-1:0] rd_cnt, cn;
	logic [31:0]   qn;
	logic          last_tick;
	logic [TW-1:0] next_t;
	logic [HW+1:0] tail_sum;
	logic [HW-1:0] tail_slot;
	logic [TW-1:0] in_tick;
	logic          out_load;

	// Store address of a slot within the level at tick t.
	function automatic logic [SAW-1:0] slot_addr(logic [TW-1:0] t, logic [HW-1:0] s);
		return SAW'(32'(t) * 32'(LEVEL_DEPTH) + 32'(s));
	endfunction

	assign rd_head   = lvl_rdata[HW+CW-1:CW];
	assign rd_cnt    = lvl_rdata[CW-1:0];
	assign last_tick = (t_q == tick_q);
	assign next_t    = side_q ? (t_q - 1'b1) : (t_q + 1'b1);
	assign hn        = (head_q == HEAD_MAX) ? '0 : (head_q + 1'b1);
	assign cn        = cnt_q - 1'b1;
	assign qn        = qty_q - qty_rdata;

	// Tail slot of the own level, wrapping round the circular FIFO.
	assign tail_sum  = (HW+2)'(rd_head) + (HW+2)'(rd_cnt);
	assign tail_slot = (tail_sum >= (HW+2)'(LEVEL_DEPTH)) ?
		HW'(tail_sum - (HW+2)'(LEVEL_DEPTH)) : HW'(tail_sum);

	// Prices beyond the ladder saturate to the top tick.
	assign in_tick = (32'(in_data.price_tick) >= 32'(PRICE_LEVELS)) ?
		TICK_MAX : TW'(in_data.price_tick);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Next state and datapath.
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		id_d        = id_q;
		side_d      = side_q;
		tick_d      = tick_q;
		t_d         = t_q;
		qty_d       = qty_q;
		orig_d      = orig_q;
		head_d      = head_q;
		cnt_d       = cnt_q;
		rested_d    = rested_q;
		dropped_d   = dropped_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		lvl_we      = 1'b0;
		lvl_waddr   = {~side_q, t_q};
		lvl_wdata   = {head_q, cnt_q};
		lvl_raddr   = {~side_q, t_q};
		qty_we      = 1'b0;
		qty_waddr   = {~side_q, slot_addr(t_q, head_q)};
		qty_wdata   = qty_rdata - qty_q;
		qty_raddr   = {~side_q, slot_addr(t_q, head_q)};

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_CLEAR: begin
				lvl_we    = 1'b1;
				lvl_waddr = clr_q;
				lvl_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					id_d      = in_data.order_ref;
					side_d    = in_data.side;
					tick_d    = in_tick;
					qty_d     = in_data.quantity;
					orig_d    = in_data.quantity;
					rested_d  = '0;
					dropped_d = 1'b0;
					t_d       = (in_data.side == SIDE_SELL) ? TICK_MAX : '0;
					state_d   = (in_data.quantity == '0) ? ST_DONE : ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				head_d = rd_head;
				cnt_d  = rd_cnt;
				if (rd_cnt != '0) begin
					qty_raddr = {~side_q, slot_addr(t_q, rd_head)};
					state_d   = ST_MATCH;
				end else if (last_tick) begin
					state_d = ST_REST_RD;
				end else begin
					t_d     = next_t;
					state_d = ST_SCAN_RD;
				end
			end
			ST_MATCH: begin
				if (qty_rdata <= qty_q) begin
					// Resting order filled in full: pop it.
					qty_d     = qn;
					head_d    = hn;
					cnt_d     = cn;
					lvl_we    = 1'b1;
					lvl_wdata = {hn, cn};
					qty_raddr = {~side_q, slot_addr(t_q, hn)};
					if (cn != '0 && qn != '0) begin
						state_d = ST_MATCH;
					end else if (qn == '0 || last_tick) begin
						state_d = ST_REST_RD;
					end else begin
						t_d     = next_t;
						state_d = ST_SCAN_RD;
					end
				end else begin
					// Resting order filled in part: it shrinks in place.
					qty_we  = 1'b1;
					qty_d   = '0;
					state_d = ST_REST_RD;
				end
			end
			ST_REST_RD: begin
				lvl_raddr = {side_q, tick_q};
				state_d   = (qty_q == '0) ? ST_DONE : ST_REST_CHK;
			end
			ST_REST_CHK: begin
				if (rd_cnt >= CNT_FULL) begin
					dropped_d = 1'b1;
				end else begin
					qty_we    = 1'b1;
					qty_waddr = {side_q, slot_addr(tick_q, tail_slot)};
					qty_wdata = qty_q;
					lvl_we    = 1'b1;
					lvl_waddr = {side_q, tick_q};
					lvl_wdata = {rd_head, rd_cnt + 1'b1};
					rested_d  = qty_q;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					out_d.ack_id          = id_q;
					out_d.filled_quantity = orig_q - qty_q;
					out_d.rested_quantity = rested_q;
					out_d.rest_dropped    = dropped_q;
					out_valid_d           = 1'b1;
					state_d               = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		id_q      <= id_d;
		side_q    <= side_d;
		tick_q    <= tick_d;
		t_q       <= t_d;
		qty_q     <= qty_d;
		orig_q    <= orig_d;
		head_q    <= head_d;
		cnt_q     <= cnt_d;
		rested_q  <= rested_d;
		dropped_q <= dropped_d;
		out_q     <= out_d;
	end

	// Checks on the sequencer.
	`LOBM_NEVER(a_no_accept_in_clear, (state_q == ST_CLEAR) && in_ready, "order taken during clear")
	`LOBM_NEVER(a_rest_not_full, (state_q == ST_REST_CHK) && lvl_we && (rd_cnt >= CNT_FULL), "rest into full level")
	`LOBM_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_q == ST_SCAN_RD || state_q == ST_DONE), "bad start after accept")
	`LOBM_NEVER(a_rest_and_drop, out_load && (rested_q != '0) && dropped_q, "rested and dropped together")
	`LOBM_ASSERT(a_qty_shrinks, (state_q == ST_MATCH) |=> (qty_q <= $past(qty_q)), "remainder grew while matching")

endmodule

// ----- sv/limit_order_book_matcher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority limit order book: matches each order against the
// opposite side, rests any remainder and returns one acknowledgement.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------
//  in      | in_valid / in_ready    | in_data  (order_t)
//  out     | out_valid / out_ready  | out_data (ack_t)
//
// An order scans price levels in turn, fills resting orders one by one and
// rests any remainder; a zero quantity skips to its ack. After reset a clearing
// pass writes every level entry, and no order is taken meanwhile.
// A waiting acknowledgement does not stop the next order being taken; it
// only holds that order's final step until the output beat is taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
	parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
	parameter int LEVEL_DEPTH  = lobm_pkg::LEVEL_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lobm_pkg::order_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lobm_pkg::ack_t   out_data
);
	import lobm_pkg::*;

	localparam int TW  = $clog2(PRICE_LEVELS);
	localparam int HW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CW  = $clog2(LEVEL_DEPTH + 1);
	localparam int SAW = $clog2(PRICE_LEVELS * LEVEL_DEPTH);

	logic             lvl_we;
	logic [TW:0]      lvl_waddr, lvl_raddr;
	logic [HW+CW-1:0] lvl_wdata, lvl_rdata;
	logic             qty_we;
	logic [SAW:0]     qty_waddr, qty_raddr;
	logic [31:0]      qty_wdata, qty_rdata;

	// Sequencer and shared compare and subtract unit.
	lobm_seq #(
		.PRICE_LEVELS(PRICE_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.TW          (TW),
		.HW          (HW),
		.CW          (CW),
		.SAW         (SAW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.lvl_we   (lvl_we),
		.lvl_waddr(lvl_waddr),
		.lvl_wdata(lvl_wdata),
		.lvl_raddr(lvl_raddr),
		.lvl_rdata(lvl_rdata),
		.qty_we   (qty_we),
		.qty_waddr(qty_waddr),
		.qty_wdata(qty_wdata),
		.qty_raddr(qty_raddr),
		.qty_rdata(qty_rdata)
	);

	// Level heads and counts, bids in the lower half, asks in the upper.
	lobm_ram #(
		.DW(HW + CW),
		.AW(TW + 1)
	) u_level_ram (
		.clk  (clk),
		.we   (lvl_we),
		.waddr(lvl_waddr),
		.wdata(lvl_wdata),
		.raddr(lvl_raddr),
		.rdata(lvl_rdata)
	);

	// Resting quantities, one circular FIFO per level and side.
	lobm_ram #(
		.DW(32),
		.AW(SAW + 1)
	) u_qty_ram (
		.clk  (clk),
		.we   (qty_we),
		.waddr(qty_waddr),
		.wdata(qty_wdata),
		.raddr(qty_raddr),
		.rdata(qty_rdata)
	);

endmodule

// ----- sim/limit_order_book_matcher_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core_test
// Self-checking bench for the order book matcher. Orders from a queue are
// driven beat by beat; a local model of the price ladder predicts every
// acknowledgement, and each output beat is compared field by field.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core_test;
	import lobm_pkg::*;

	localparam int LEVELS = PRICE_LEVELS_DEF;
	localparam int DEPTH  = LEVEL_DEPTH_DEF;
	localparam int RANDOM_ORDERS = 1030;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	order_t in_data = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	ack_t   out_data;

	limit_order_book_matcher_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// Book state: resting quantities and per-level FIFO head and count.
	// Bid levels sit at index tick, ask levels at LEVELS + tick.
	logic [31:0] bid_rest [LEVELS*DEPTH];
	logic [31:0] ask_rest [LEVELS*DEPTH];
	int          lvl_head [2*LEVELS];
	int          lvl_count[2*LEVELS];

	order_t pending_orders[$];
	ack_t   expected_acks[$];
	int     orders_taken = 0;
	int     mismatches = 0;
	int     total_orders = 0;
	bit     order_taken = 1'b0;
	bit     hold_for_drain = 1'b0;
	int     sender_idle_pct, receiver_idle_pct;

	// Consume resting orders at one level and return what is left.
	function automatic logic [31:0] drain_level(bit ask, int tick, logic [31:0] qty);
		int li, slot;
		logic [31:0] r;
		li = ask ? LEVELS + tick : tick;
		while (qty != 0 && lvl_count[li] != 0) begin
			slot = tick * DEPTH + lvl_head[li];
			r = ask ? ask_rest[slot] : bid_rest[slot];
			if (r <= qty) begin
				qty -= r;
				lvl_head[li] = (lvl_head[li] + 1) % DEPTH;
				lvl_count[li]--;
			end else begin
				if (ask) ask_rest[slot] = r - qty;
				else bid_rest[slot] = r - qty;
				qty = 0;
			end
		end
		return qty;
	endfunction

	// Match one order against the book and return its acknowledgement.
	function automatic ack_t match_order(order_t o);
		ack_t a;
		logic [31:0] qty;
		int tick, t, li, slot;
		bit ask_side;
		qty = o.quantity;
		tick = (o.price_tick >= LEVELS) ? LEVELS - 1 : o.price_tick;
		ask_side = (o.side == SIDE_SELL);
		if (!ask_side) begin
			for (t = 0; t <= tick && qty != 0; t++)
				qty = drain_level(1'b1, t, qty);
		end else begin
			for (t = LEVELS - 1; t >= tick && qty != 0; t--)
				qty = drain_level(1'b0, t, qty);
		end
		a.ack_id = o.order_ref;
		a.filled_quantity = o.quantity - qty;
		a.rested_quantity = '0;
		a.rest_dropped = 1'b0;
		if (qty != 0) begin
			li = ask_side ? LEVELS + tick : tick;
			if (lvl_count[li] >= DEPTH) begin
				a.rest_dropped = 1'b1;
			end else begin
				slot = tick * DEPTH + (lvl_head[li] + lvl_count[li]) % DEPTH;
				if (ask_side) ask_rest[slot] = qty;
				else bid_rest[slot] = qty;
				lvl_count[li]++;
				a.rested_quantity = qty;
			end
		end
		return a;
	endfunction

	task automatic add_order(logic [63:0] id, logic side, logic [9:0] px, logic [31:0] qty);
		order_t o;
		o.order_ref = id;
		o.side = side;
		o.price_tick = px;
		o.quantity = qty;
		pending_orders.insert(pending_orders.size(), o);
	endtask

	// Idle rates follow the share of orders already taken.
	always_comb begin
		if (orders_taken < total_orders / 3) begin
			sender_idle_pct = 18;
			receiver_idle_pct = 49;
		end else if (orders_taken < 2 * total_orders / 3) begin
			sender_idle_pct = 49;
			receiver_idle_pct = 18;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
	end

	// Driver: presents orders at the falling edge and holds each until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || order_taken) begin
				if (pending_orders.size() != 0 && !hold_for_drain &&
				    $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_orders.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Monitor: predicts on each input beat and checks each output beat.
	always @(posedge clk) begin
		ack_t exp_ack;
		order_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_acks.insert(expected_acks.size(), match_order(in_data));
			orders_taken <= orders_taken + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_acks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected acknowledgement beat: %p", out_data);
			end else begin
				exp_ack = expected_acks.pop_front();
				if (out_data.ack_id !== exp_ack.ack_id) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ack_id: expected %h, got %h",
							exp_ack.ack_id, out_data.ack_id);
				end
				if (out_data.filled_quantity !== exp_ack.filled_quantity) begin
					mismatches++;
					if (mismatches <= 10)
						$display("filled_quantity (id %h): expected %0d, got %0d",
							exp_ack.ack_id, exp_ack.filled_quantity,
							out_data.filled_quantity);
				end
				if (out_data.rested_quantity !== exp_ack.rested_quantity) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rested_quantity (id %h): expected %0d, got %0d",
							exp_ack.ack_id, exp_ack.rested_quantity,
							out_data.rested_quantity);
				end
				if (out_data.rest_dropped !== exp_ack.rest_dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rest_dropped (id %h): expected %0b, got %0b",
							exp_ack.ack_id, exp_ack.rest_dropped,
							out_data.rest_dropped);
				end
			end
		end
	end

	// Watchdog for a hung run.
	initial begin
		#300ms;
		$display("limit_order_book_matcher_core_test: done, errors");
		$finish;
	end

	initial begin
		int i, kind;
		logic [63:0] id;
		for (i = 0; i < 2 * LEVELS; i++) begin
			lvl_head[i] = 0;
			lvl_count[i] = 0;
		end

		// Directed orders: empty order, ladder ends, full quantity, full level.
		add_order(64'h0, SIDE_BUY, 10'd0, 32'd0);
		add_order(64'hFFFF_FFFF_FFFF_FFFF, SIDE_SELL, 10'd1023, 32'hFFFF_FFFF);
		add_order(64'h1, SIDE_BUY, 10'd1023, 32'hFFFF_FFFF);
		for (i = 0; i < DEPTH + 1; i++)
			add_order(64'h100 + i, SIDE_BUY, 10'd0, 32'd1);
		add_order(64'h200, SIDE_SELL, 10'd0, 32'd20);
		add_order(64'h201, SIDE_BUY, 10'd0, 32'd2);
		add_order(64'h202, SIDE_BUY, 10'd1023, 32'd1);
		add_order(64'h203, SIDE_SELL, 10'd512, 32'd0);

		// Random orders, mostly in a narrow band so that books build and cross.
		for (i = 0; i < RANDOM_ORDERS; i++) begin
			id = {$urandom, $urandom};
			kind = $urandom_range(0, 99);
			if (kind < 60)
				add_order(id, 1'($urandom_range(0, 1)),
					10'(500 + $urandom_range(0, 15)), $urandom_range(1, 200));
			else if (kind < 80)
				add_order(id, 1'($urandom_range(0, 1)),
					10'(508 + $urandom_range(0, 3)), $urandom_range(1, 30));
			else if (kind < 95)
				add_order(id, 1'($urandom_range(0, 1)),
					10'($urandom_range(0, 1023)), $urandom);
			else
				add_order(id, 1'($urandom_range(0, 1)),
					10'($urandom_range(0, 1023)), 32'd0);
		end
		total_orders = pending_orders.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Hold the sender once until every acknowledgement has come back.
		wait (orders_taken >= total_orders / 2);
		hold_for_drain = 1'b1;
		wait (!in_valid && expected_acks.size() == 0);
		repeat (20) @(posedge clk);
		hold_for_drain = 1'b0;

		wait (pending_orders.size() == 0 && !in_valid && expected_acks.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_acks.size() == 0)
			$display("limit_order_book_matcher_core_test: done, clean");
		else
			$display("limit_order_book_matcher_core_test: done, errors");
		$finish;
	end

endmodule
